FILE: hw/rtl/bat_pkg.sv
// Shared constants, register codes and the configuration struct of the block-average trigger.
package bat_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int SPB_W      = 7;
  localparam int TRIG_W     = 10;
  localparam int TICKS_W    = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  localparam int DEF_MAX_BLOCK  = 64;
  localparam int DEF_TIMER_BITS = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_BLOCK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_LEVEL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_TICKS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ON_TICKS          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_HOOK_ENABLE  = 3'd4;

  localparam logic [SPB_W-1:0]   SPB_RST     = 7'd20;
  localparam logic [TRIG_W-1:0]  TRIG_RST    = 10'd100;
  localparam logic [TICKS_W-1:0] HOLDOFF_RST = 16'd3000;
  localparam logic [TICKS_W-1:0] ON_RST      = 16'd500;

  typedef struct packed {
    logic [SPB_W-1:0]   samples_per_block;
    logic [TRIG_W-1:0]  trigger_level;
    logic [TICKS_W-1:0] holdoff_ticks;
    logic [TICKS_W-1:0] on_ticks;
    logic               auto_hook_enable;
  } bat_cfg_t;

endpackage

FILE: hw/rtl/bat_regs.sv
// Configuration register file of the block-average trigger.
module bat_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bat_pkg::CFG_DATA_W-1:0] cfg_data,
  output bat_pkg::bat_cfg_t              cfg
);
  import bat_pkg::*;

  bat_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.samples_per_block <= SPB_RST;
      cfg_r.trigger_level     <= TRIG_RST;
      cfg_r.holdoff_ticks     <= HOLDOFF_RST;
      cfg_r.on_ticks          <= ON_RST;
      cfg_r.auto_hook_enable  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLES_PER_BLOCK: cfg_r.samples_per_block <= cfg_data[SPB_W-1:0];
        REG_TRIGGER_LEVEL:     cfg_r.trigger_level     <= cfg_data[TRIG_W-1:0];
        REG_HOLDOFF_TICKS:     cfg_r.holdoff_ticks     <= cfg_data[TICKS_W-1:0];
        REG_ON_TICKS:          cfg_r.on_ticks          <= cfg_data[TICKS_W-1:0];
        REG_AUTO_HOOK_ENABLE:  cfg_r.auto_hook_enable  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/bat_div.sv
// Iterative restoring divider that produces one quotient bit per cycle.
module bat_div #(
  parameter int CNT_W = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [bat_pkg::SAMPLE_W-1:0] dividend,
  input  logic [CNT_W-1:0]             divisor,
  output logic                         busy,
  output logic                         done,
  output logic [bat_pkg::SAMPLE_W-1:0] quotient
);
  import bat_pkg::*;

  localparam int STEP_W = (SAMPLE_W > 1) ? $clog2(SAMPLE_W) : 1;

  logic                busy_r;
  logic                done_r;
  logic [STEP_W-1:0]   step_r;
  logic [CNT_W-1:0]    rem_r;
  logic [CNT_W-1:0]    div_r;
  logic [SAMPLE_W-1:0] quo_r;
  logic [CNT_W:0]      shifted;
  logic                fits;
  logic [CNT_W:0]      diff;

  always_comb begin
    shifted = {rem_r, quo_r[SAMPLE_W-1]};
    fits    = shifted >= {1'b0, div_r};
    diff    = shifted - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= STEP_W'(SAMPLE_W - 1);
    end else if (busy_r) begin
      step_r <= step_r - 1'b1;
      if (step_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      div_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo_r <= {quo_r[SAMPLE_W-2:0], fits};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: hw/rtl/block_average_trigger_pulse.sv
// Top level of the block-average trigger with drive pulse timer.
//
// The input channel (in_valid, in_stall, in_action, in_sample) carries one
// transaction per ADC sample (action 0) or per 1 ms tick (action 1). Every
// input transaction yields exactly one output transaction on out_valid and
// out_stall, holding block_done, block_mean, drive_on and the on/off pulses.
// A sample occupies the block from accept to commit: the mean update divides
// by the running count in a restoring divider that retires one quotient bit
// per cycle, and the sequencer then hands off to commit. A tick goes from
// accept straight to commit. The result is written into the output register
// at commit, and in_stall is high while an item is in progress.
// When the receiver stalls, the finished result waits in the output register
// and a following item waits before commit until the register is taken.
// Configuration writes are taken at any edge with cfg_we high and should be
// made only while the block is idle. Synchronous reset loads the register
// defaults, clears mean, count, timer and drive, and empties the output.
module block_average_trigger_pulse #(
  parameter int MAX_BLOCK  = bat_pkg::DEF_MAX_BLOCK,
  parameter int TIMER_BITS = bat_pkg::DEF_TIMER_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_action,
  input  logic [bat_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_block_done,
  output logic [bat_pkg::SAMPLE_W-1:0]   out_block_mean,
  output logic                           out_drive_on,
  output logic                           out_turned_on,
  output logic                           out_turned_off,
  input  logic                           cfg_we,
  input  logic [bat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bat_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bat_pkg::*;

  localparam int CNT_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK + 1) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  bat_cfg_t cfg;

  logic [1:0]            state_r;
  logic [1:0]            state_nxt;
  logic                  act_r;
  logic                  neg_r;
  logic [SAMPLE_W-1:0]   running_mean_r;
  logic [CNT_W-1:0]      sample_count_r;
  logic [SAMPLE_W-1:0]   last_mean_r;
  logic                  drive_r;
  logic [TIMER_BITS-1:0] elapsed_r;

  logic                  out_valid_r;
  logic                  out_block_done_r;
  logic [SAMPLE_W-1:0]   out_block_mean_r;
  logic                  out_drive_on_r;
  logic                  out_turned_on_r;
  logic                  out_turned_off_r;

  logic                  in_acc;
  logic                  commit;
  logic [CNT_W-1:0]      blk_n;
  logic [CNT_W-1:0]      cnt_new;
  logic [SAMPLE_W:0]     diff;
  logic [SAMPLE_W:0]     mag;
  logic                  div_start;
  logic                  div_busy;
  logic                  div_done;
  logic [SAMPLE_W-1:0]   quo;
  logic [SAMPLE_W-1:0]   mean_new;
  logic                  blk_end;
  logic                  trig;
  logic                  holdoff_met;
  logic [TIMER_BITS-1:0] el_inc;
  logic                  off_now;

  bat_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  always_comb begin
    if (cfg.samples_per_block == '0) begin
      blk_n = CNT_W'(1);
    end else if (int'(cfg.samples_per_block) > MAX_BLOCK) begin
      blk_n = CNT_W'(MAX_BLOCK);
    end else begin
      blk_n = CNT_W'(cfg.samples_per_block);
    end
    cnt_new = (sample_count_r >= blk_n) ? CNT_W'(1) : sample_count_r + 1'b1;
    diff    = {1'b0, in_sample} - {1'b0, running_mean_r};
    mag     = diff[SAMPLE_W] ? ('0 - diff) : diff;
  end

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign div_start = in_acc && !in_action;
  assign commit    = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  bat_div #(
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag[SAMPLE_W-1:0]),
    .divisor  (cnt_new),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    mean_new    = neg_r ? (running_mean_r - quo) : (running_mean_r + quo);
    blk_end     = !act_r && (sample_count_r == blk_n);
    trig        = blk_end && !drive_r && (mean_new >= cfg.trigger_level)
                  && cfg.auto_hook_enable;
    holdoff_met = 32'(elapsed_r) > 32'(cfg.holdoff_ticks);
    el_inc      = (elapsed_r != '1) ? elapsed_r + 1'b1 : elapsed_r;
    off_now     = act_r && drive_r && (32'(el_inc) > 32'(cfg.on_ticks));
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = in_action ? ST_FIN : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      running_mean_r <= '0;
      sample_count_r <= '0;
      last_mean_r    <= '0;
      drive_r        <= 1'b0;
      elapsed_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (div_start) begin
        sample_count_r <= cnt_new;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
        if (act_r) begin
          elapsed_r <= el_inc;
          if (off_now) begin
            drive_r <= 1'b0;
          end
        end else if (blk_end) begin
          last_mean_r    <= mean_new;
          running_mean_r <= '0;
          if (trig) begin
            elapsed_r <= '0;
            if (holdoff_met) begin
              drive_r <= 1'b1;
            end
          end
        end else begin
          running_mean_r <= mean_new;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= in_action;
      neg_r <= diff[SAMPLE_W];
    end
    if (commit) begin
      out_block_done_r <= blk_end;
      out_block_mean_r <= blk_end ? mean_new : last_mean_r;
      out_drive_on_r   <= off_now ? 1'b0 : ((trig && holdoff_met) ? 1'b1 : drive_r);
      out_turned_on_r  <= trig && holdoff_met;
      out_turned_off_r <= off_now;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_block_done = out_block_done_r;
  assign out_block_mean = out_block_mean_r;
  assign out_drive_on   = out_drive_on_r;
  assign out_turned_on  = out_turned_on_r;
  assign out_turned_off = out_turned_off_r;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ST_IDLE))
    else $error("accepted transaction did not leave idle");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !div_busy)
    else $error("divider busy while the sequencer is idle");

  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("committed result not presented");

  a_pulse_level: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (out_turned_on_r == (drive_r && !$past(drive_r)))
               && (out_turned_off_r == (!drive_r && $past(drive_r))))
    else $error("drive pulse does not match drive change");
`endif

endmodule

FILE: tb/block_average_trigger_pulse_tb.sv
// Self-checking testbench for the block-average trigger with drive pulse timer.
`timescale 1ns / 1ps

module block_average_trigger_pulse_tb;
  import bat_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 11;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int MAX_BLOCK      = DEF_MAX_BLOCK;
  localparam int RANDOM_PHASES  = 16;
  localparam int PHASE_ITEMS    = 100;
  localparam int HOLD_TICKS     = 20;

  localparam logic [TICKS_W-1:0]  TICKS_MAX      = '1;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX     = '1;
  localparam logic [TRIG_W-1:0]   TRIG_MAX       = '1;
  localparam logic [SPB_W-1:0]    SPB_MAX        = '1;

  typedef enum logic {ACT_SAMPLE = 1'b0, ACT_TICK = 1'b1} action_e;
  typedef enum logic {ROW_ITEM = 1'b0, ROW_CFG = 1'b1} row_kind_e;

  typedef struct packed {
    logic                block_done;
    logic [SAMPLE_W-1:0] block_mean;
    logic                drive_on;
    logic                turned_on;
    logic                turned_off;
  } trigger_result_t;

  typedef struct packed {
    row_kind_e            kind;
    action_e              action;
    logic [SAMPLE_W-1:0]  sample;
    logic                 has_result;
    trigger_result_t      result;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DATA_W-1:0] value;
  } stim_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic                  in_action  = 1'b0;
  logic [SAMPLE_W-1:0]   in_sample  = '0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic                  out_block_done;
  logic [SAMPLE_W-1:0]   out_block_mean;
  logic                  out_drive_on;
  logic                  out_turned_on;
  logic                  out_turned_off;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  bat_cfg_t            mdl_cfg;
  logic [SAMPLE_W-1:0] mdl_mean;
  logic [SPB_W-1:0]    mdl_count;
  logic [SAMPLE_W-1:0] mdl_last;
  logic                mdl_drive;
  logic [TICKS_W-1:0]  mdl_elapsed;

  trigger_result_t pending_results[$];
  stim_row_t       stim_table[$];
  trigger_result_t got_result;
  trigger_result_t want_result;
  int              mismatch_count = 0;
  int              idle_cycles    = 0;
  int              sender_idle_pct = 0;
  int              recv_stall_pct  = 0;

  block_average_trigger_pulse dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_block_done (out_block_done),
    .out_block_mean (out_block_mean),
    .out_drive_on   (out_drive_on),
    .out_turned_on  (out_turned_on),
    .out_turned_off (out_turned_off),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  function automatic trigger_result_t trigger_model_step(action_e action,
                                                         logic [SAMPLE_W-1:0] sample);
    trigger_result_t r;
    int n;
    int m;
    r = '0;
    if (action == ACT_SAMPLE) begin
      n = int'(mdl_cfg.samples_per_block);
      if (n == 0) n = 1;
      if (n > MAX_BLOCK) n = MAX_BLOCK;
      if (int'(mdl_count) >= n) mdl_count = '0;
      mdl_count = mdl_count + 1'b1;
      m = int'(mdl_mean);
      m = m + (int'(sample) - m) / int'(mdl_count);
      mdl_mean = m[SAMPLE_W-1:0];
      if (int'(mdl_count) == n) begin
        r.block_done = 1'b1;
        if (!mdl_drive && mdl_mean >= mdl_cfg.trigger_level && mdl_cfg.auto_hook_enable) begin
          if (mdl_elapsed > mdl_cfg.holdoff_ticks) begin
            mdl_drive   = 1'b1;
            r.turned_on = 1'b1;
          end
          mdl_elapsed = '0;
        end
        mdl_last = mdl_mean;
        mdl_mean = '0;
      end
    end else begin
      if (mdl_elapsed != TICKS_MAX) mdl_elapsed = mdl_elapsed + 1'b1;
      if (mdl_drive && mdl_elapsed > mdl_cfg.on_ticks) begin
        mdl_drive    = 1'b0;
        r.turned_off = 1'b1;
      end
    end
    r.block_mean = mdl_last;
    r.drive_on   = mdl_drive;
    return r;
  endfunction

  function automatic logic [TICKS_W-1:0] rand_ticks();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return TICKS_MAX;
      2: return TICKS_W'($urandom);
      default: return TICKS_W'($urandom_range(0, 30));
    endcase
  endfunction

  task automatic add_item(action_e action, logic [SAMPLE_W-1:0] sample);
    stim_row_t row;
    row        = '0;
    row.kind   = ROW_ITEM;
    row.action = action;
    row.sample = sample;
    stim_table.push_back(row);
  endtask

  task automatic add_check(action_e action, logic [SAMPLE_W-1:0] sample,
                           trigger_result_t result);
    stim_row_t row;
    row            = '0;
    row.kind       = ROW_ITEM;
    row.action     = action;
    row.sample     = sample;
    row.has_result = 1'b1;
    row.result     = result;
    stim_table.push_back(row);
  endtask

  task automatic add_cfg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
    stim_row_t row;
    row       = '0;
    row.kind  = ROW_CFG;
    row.index = index;
    row.value = value;
    stim_table.push_back(row);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    case (index)
      REG_SAMPLES_PER_BLOCK: mdl_cfg.samples_per_block = value[SPB_W-1:0];
      REG_TRIGGER_LEVEL:     mdl_cfg.trigger_level     = value[TRIG_W-1:0];
      REG_HOLDOFF_TICKS:     mdl_cfg.holdoff_ticks     = value[TICKS_W-1:0];
      REG_ON_TICKS:          mdl_cfg.on_ticks          = value[TICKS_W-1:0];
      REG_AUTO_HOOK_ENABLE:  mdl_cfg.auto_hook_enable  = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_item(action_e action, logic [SAMPLE_W-1:0] sample,
                           logic has_result = 1'b0, trigger_result_t result = '0);
    int gap;
    trigger_result_t predicted;
    cfg_we <= 1'b0;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      gap = $urandom_range(1, 20);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= action;
    in_sample <= sample;
    do @(posedge clk); while (in_stall);
    predicted = trigger_model_step(action, sample);
    pending_results.push_back(has_result ? result : predicted);
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_result = {out_block_done, out_block_mean, out_drive_on, out_turned_on,
                    out_turned_off};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: expected no transaction, actual done=%0d mean=%0d drive=%0d on=%0d off=%0d",
                 $time, got_result.block_done, got_result.block_mean, got_result.drive_on,
                 got_result.turned_on, got_result.turned_off);
      end else begin
        want_result = pending_results.pop_front();
        if (got_result !== want_result) begin
          mismatch_count++;
          $display("%0t: expected done=%0d mean=%0d drive=%0d on=%0d off=%0d, actual done=%0d mean=%0d drive=%0d on=%0d off=%0d",
                   $time, want_result.block_done, want_result.block_mean,
                   want_result.drive_on, want_result.turned_on, want_result.turned_off,
                   got_result.block_done, got_result.block_mean, got_result.drive_on,
                   got_result.turned_on, got_result.turned_off);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int phase;
    int k;
    int near;
    logic [SPB_W-1:0]    spb;
    logic [TRIG_W-1:0]   trig;
    logic [SAMPLE_W-1:0] smp;
    action_e             act;

    mdl_cfg     = {SPB_RST, TRIG_RST, HOLDOFF_RST, ON_RST, 1'b1};
    mdl_mean    = '0;
    mdl_count   = '0;
    mdl_last    = '0;
    mdl_drive   = 1'b0;
    mdl_elapsed = '0;

    add_check(ACT_TICK, SAMPLE_MAX, {1'b0, 10'd0, 1'b0, 1'b0, 1'b0});
    add_cfg(REG_SAMPLES_PER_BLOCK, 16'd1);
    add_cfg(REG_TRIGGER_LEVEL, CFG_DATA_W'(TRIG_MAX));
    add_cfg(REG_HOLDOFF_TICKS, 16'd0);
    add_cfg(REG_ON_TICKS, 16'd2);
    add_check(ACT_SAMPLE, SAMPLE_MAX, {1'b1, 10'd1023, 1'b1, 1'b1, 1'b0});
    add_check(ACT_SAMPLE, 10'd0, {1'b1, 10'd0, 1'b1, 1'b0, 1'b0});
    add_item(ACT_TICK, 10'd0);
    add_item(ACT_TICK, 10'h2AA);
    add_check(ACT_TICK, 10'h155, {1'b0, 10'd0, 1'b0, 1'b0, 1'b1});
    add_cfg(REG_SAMPLES_PER_BLOCK, 16'd0);
    add_item(ACT_SAMPLE, 10'd512);
    add_cfg(REG_SAMPLES_PER_BLOCK, CFG_DATA_W'(SPB_MAX));
    add_cfg(REG_TRIGGER_LEVEL, 16'd0);
    add_cfg(REG_HOLDOFF_TICKS, CFG_DATA_W'(TICKS_MAX));
    add_cfg(REG_AUTO_HOOK_ENABLE, 16'd0);
    add_item(ACT_SAMPLE, SAMPLE_MAX);
    add_item(ACT_SAMPLE, 10'd0);
    add_item(ACT_SAMPLE, SAMPLE_MAX);
    add_item(ACT_SAMPLE, 10'd1);
    add_item(ACT_SAMPLE, 10'd700);
    add_cfg(REG_SAMPLES_PER_BLOCK, 16'd3);
    add_item(ACT_SAMPLE, 10'd300);
    add_item(ACT_SAMPLE, 10'd5);
    add_item(ACT_SAMPLE, SAMPLE_MAX);
    add_cfg(REG_AUTO_HOOK_ENABLE, 16'd1);
    add_item(ACT_TICK, SAMPLE_MAX);
    add_item(ACT_SAMPLE, 10'd17);
    add_item(ACT_SAMPLE, 10'd900);
    add_item(ACT_SAMPLE, 10'd33);
    add_cfg(REG_HOLDOFF_TICKS, 16'd0);
    add_cfg(REG_ON_TICKS, 16'd0);
    add_item(ACT_TICK, 10'd0);
    add_item(ACT_SAMPLE, 10'd1000);
    add_item(ACT_SAMPLE, 10'd2);
    add_item(ACT_SAMPLE, 10'd511);
    add_item(ACT_TICK, 10'd0);
    add_item(ACT_SAMPLE, 10'd64);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = 14;
    recv_stall_pct  = 14;
    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_CFG) begin
        wait_idle();
        cfg_write(stim_table[i].index, stim_table[i].value);
      end else begin
        send_item(stim_table[i].action, stim_table[i].sample, stim_table[i].has_result,
                  stim_table[i].result);
      end
    end

    // Drive held on over a run of ticks, then the on and holdoff limits are each passed by one tick.
    wait_idle();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    cfg_write(REG_SAMPLES_PER_BLOCK, 16'd1);
    cfg_write(REG_TRIGGER_LEVEL, 16'd0);
    cfg_write(REG_HOLDOFF_TICKS, 16'd0);
    cfg_write(REG_ON_TICKS, CFG_DATA_W'(TICKS_MAX));
    cfg_write(REG_AUTO_HOOK_ENABLE, 16'd1);
    send_item(ACT_TICK, SAMPLE_W'($urandom));
    send_item(ACT_SAMPLE, SAMPLE_W'($urandom));
    repeat (HOLD_TICKS) send_item(ACT_TICK, SAMPLE_W'($urandom));
    wait_idle();
    cfg_write(REG_ON_TICKS, CFG_DATA_W'(HOLD_TICKS));
    send_item(ACT_TICK, SAMPLE_W'($urandom));
    wait_idle();
    cfg_write(REG_HOLDOFF_TICKS, CFG_DATA_W'(HOLD_TICKS));
    send_item(ACT_SAMPLE, SAMPLE_W'($urandom));

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      case (phase % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin sender_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      case ($urandom_range(0, 9))
        0: spb = '0;
        1: spb = 7'd1;
        2, 3, 4, 5: spb = SPB_W'($urandom_range(2, 6));
        6: spb = SPB_W'($urandom_range(7, 16));
        7: spb = SPB_W'(MAX_BLOCK);
        8: spb = SPB_W'($urandom_range(MAX_BLOCK + 1, int'(SPB_MAX)));
        default: spb = SPB_W'($urandom_range(1, MAX_BLOCK));
      endcase
      case ($urandom_range(0, 4))
        0: trig = '0;
        1: trig = TRIG_MAX;
        2: trig = TRIG_W'($urandom);
        default: trig = TRIG_W'($urandom_range(200, 800));
      endcase
      cfg_write(REG_SAMPLES_PER_BLOCK, CFG_DATA_W'(spb));
      cfg_write(REG_TRIGGER_LEVEL, CFG_DATA_W'(trig));
      cfg_write(REG_HOLDOFF_TICKS, CFG_DATA_W'(rand_ticks()));
      cfg_write(REG_ON_TICKS, CFG_DATA_W'(rand_ticks()));
      cfg_write(REG_AUTO_HOOK_ENABLE, CFG_DATA_W'($urandom_range(0, 3) != 0));
      for (k = 0; k < PHASE_ITEMS; k++) begin
        case ($urandom_range(0, 5))
          0: smp = '0;
          1: smp = SAMPLE_MAX;
          2, 3: smp = SAMPLE_W'($urandom);
          default: begin
            near = int'(mdl_cfg.trigger_level) + $urandom_range(0, 16) - 8;
            if (near < 0) near = 0;
            if (near > int'(SAMPLE_MAX)) near = int'(SAMPLE_MAX);
            smp = SAMPLE_W'(near);
          end
        endcase
        act = ($urandom_range(0, 99) < 35) ? ACT_TICK : ACT_SAMPLE;
        send_item(act, smp);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
